@@ sv/bfra_pkg.sv @@
package bfra_pkg;

  localparam int CAPACITY   = 2048;
  localparam int OWNER_BITS = 8;
  localparam int ADDR_W     = $clog2(CAPACITY);
  // wide enough to hold one past the end of the map
  localparam int CNT_W      = $clog2(CAPACITY + 2);
  localparam int TAG_W      = OWNER_BITS + 1;
  localparam int LEN_W      = 12;
  localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic clr;
    logic eval;
    logic empty;
    cnt_t idx;
  } bfra_eval_t;

  typedef struct packed {
    logic  found;
    logic  hit;
    addr_t start;
  } bfra_verdict_t;

endpackage

@@ sv/bfra_ram.sv @@
module bfra_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bfra_run_unit.sv @@
module bfra_run_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfra_pkg::bfra_eval_t        ev,
  input  logic [bfra_pkg::LEN_W-1:0]  len,
  output bfra_pkg::bfra_verdict_t     vd
);
  import bfra_pkg::*;

  cnt_t  run_r, run_nxt;
  addr_t run_start_r, run_start_nxt;
  cnt_t  best_len_r, best_len_nxt;
  addr_t best_start_r, best_start_nxt;
  logic  found_r, found_nxt;

  logic fits, better, take;

  always_comb begin
    fits   = CMP_W'(run_r) >= CMP_W'(len);
    better = !found_r || (run_r < best_len_r);
    take   = ev.eval && !ev.empty && fits && better;

    run_nxt        = run_r;
    run_start_nxt  = run_start_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    found_nxt      = found_r;

    if (ev.clr) begin
      run_nxt   = '0;
      found_nxt = 1'b0;
    end else if (ev.eval) begin
      if (ev.empty) begin
        if (run_r == '0) begin
          run_start_nxt = ev.idx[ADDR_W-1:0];
        end
        run_nxt = run_r + cnt_t'(1);
      end else begin
        // a run just closed: judge it as a whole
        if (take) begin
          found_nxt      = 1'b1;
          best_len_nxt   = run_r;
          best_start_nxt = run_start_r;
        end
        run_nxt = '0;
      end
    end

    vd.found = found_nxt;
    vd.start = best_start_nxt;
    vd.hit   = take && (CMP_W'(run_r) == CMP_W'(len));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      found_r <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      found_r <= found_nxt;
    end
    run_start_r  <= run_start_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
  end

endmodule

@@ sv/best_fit_region_allocator_top.sv @@
// Allocate: a scan of the map after acceptance (shorter on an exact fit), one write per
// allocated unit to tag it, then a load of the output register once it is free.
// Free: one write per unit in the range, then the output load; bad ranges go straight to it.
// Throughput: one item at a time; in_stall drops when the result is loaded into the output
// register, so the serial scan through the one compare unit sets the rate.
// Reset: synchronous, active low; a clearing pass then empties all CAPACITY units.
module best_fit_region_allocator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [7:0]                        in_owner,
  input  logic [10:0]                       in_start_req,
  input  logic [bfra_pkg::LEN_W-1:0]        in_length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [10:0]                       out_region_start
);
  import bfra_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  cnt_t             fill_addr_r, fill_addr_nxt;
  cnt_t             fill_end_r, fill_end_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  cnt_t             issue_r, issue_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  cnt_t             rd_idx_r, rd_idx_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  addr_t            res_start_r, res_start_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  addr_t            out_start_r, out_start_nxt;

  logic             ram_we, ram_re;
  addr_t            ram_waddr, ram_raddr;
  logic [TAG_W-1:0] ram_wdata, ram_rdata;

  bfra_eval_t    ev;
  bfra_verdict_t vd;

  logic             in_acc;
  logic [LEN_W:0]   free_end;
  logic             range_bad;

  bfra_ram #(
    .WIDTH (TAG_W),
    .DEPTH (CAPACITY)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfra_run_unit u_run (
    .clk   (clk),
    .rst_n (rst_n),
    .ev    (ev),
    .len   (len_r),
    .vd    (vd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign free_end  = (LEN_W+1)'(in_start_req) + (LEN_W+1)'(in_length);
  assign range_bad = free_end > (LEN_W+1)'(CAPACITY);

  always_comb begin
    ev.clr   = in_acc && (in_kind == KIND_ALLOC) && (in_length != '0);
    ev.eval  = rd_vld_r && (state_r == S_SCAN);
    ev.empty = (rd_idx_r < cnt_t'(CAPACITY)) && (ram_rdata == '0);
    ev.idx   = rd_idx_r;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_addr_nxt  = fill_addr_r;
    fill_end_nxt   = fill_end_r;
    tag_nxt        = tag_r;
    len_nxt        = len_r;
    issue_nxt      = issue_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;

    ram_we    = 1'b0;
    ram_waddr = fill_addr_r[ADDR_W-1:0];
    ram_wdata = tag_r;
    ram_re    = 1'b0;
    ram_raddr = issue_r[ADDR_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_wdata     = '0;
        fill_addr_nxt = fill_addr_r + cnt_t'(1);
        if (fill_addr_r == cnt_t'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = ST_DONE;
          res_start_nxt  = '0;
          if (in_kind == KIND_ALLOC) begin
            if (in_length == '0) begin
              state_nxt = S_DONE;
            end else begin
              len_nxt   = in_length;
              tag_nxt   = TAG_W'(in_owner) + TAG_W'(1);
              issue_nxt = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (range_bad) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              fill_addr_nxt = cnt_t'(in_start_req);
              fill_end_nxt  = cnt_t'(free_end);
              tag_nxt       = '0;
              state_nxt     = S_FILL;
            end
          end
        end
      end
      S_SCAN: begin
        // issue one read ahead; the slot past the map closes the last run
        if (issue_r <= cnt_t'(CAPACITY)) begin
          ram_re     = (issue_r < cnt_t'(CAPACITY));
          issue_nxt  = issue_r + cnt_t'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r;
        end
        if (ev.eval && (vd.hit || (rd_idx_r == cnt_t'(CAPACITY)))) begin
          rd_vld_nxt = 1'b0;
          if (vd.found) begin
            fill_addr_nxt = cnt_t'(vd.start);
            fill_end_nxt  = cnt_t'(vd.start) + cnt_t'(len_r);
            res_start_nxt = vd.start;
            state_nxt     = S_FILL;
          end else begin
            res_status_nxt = ST_NOFIT;
            state_nxt      = S_DONE;
          end
        end
      end
      S_FILL: begin
        if (fill_addr_r == fill_end_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_we        = 1'b1;
          fill_addr_nxt = fill_addr_r + cnt_t'(1);
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      fill_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fill_end_r   <= fill_end_nxt;
    tag_r        <= tag_nxt;
    len_r        <= len_nxt;
    issue_r      <= issue_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_start = out_start_r;

endmodule

@@ sv/bfra_checker.sv @@
module bfra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [10:0] out_region_start
);
  import bfra_pkg::*;

  // a stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_region_start))
    else $error("stalled output item changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_region_start == '0)
    else $error("failed item carries a nonzero start");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_DONE || out_status == ST_NOFIT || out_status == ST_RANGE)
    else $error("undefined status code");

  // the block works on one item at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted an item while busy");

  // reset starts the clearing pass with nothing on the output
  assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not held busy after reset");

endmodule

bind best_fit_region_allocator_top bfra_checker u_bfra_checker (.*);

@@ tb/best_fit_region_allocator_top_test.sv @@
`timescale 1ns / 1ps

module best_fit_region_allocator_top_test;
  import bfra_pkg::*;

  localparam int QUIET_LIMIT = 40000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] region_start;
  } alloc_result_t;

  typedef struct {
    int first;
    int count;
  } region_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = KIND_ALLOC;
  logic [7:0]        in_owner = '0;
  logic [10:0]       in_start_req = '0;
  logic [LEN_W-1:0]  in_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [10:0]       out_region_start;

  logic [TAG_W-1:0]  unit_tag [CAPACITY];
  alloc_result_t     pending_results [$];
  region_t           live_regions [$];
  int                error_count = 0;
  int                tx_idle_pct = 0;
  int                rx_stall_pct = 0;
  int                hold_token = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                quiet_cycles = 0;
  int                last_freed_len = 1;

  best_fit_region_allocator_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_owner         (in_owner),
    .in_start_req     (in_start_req),
    .in_length        (in_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_region_start (out_region_start)
  );

  always #5 clk = ~clk;

  // Apply one item to the ownership map and return the result it should produce.
  function automatic alloc_result_t predict_outcome(input logic kind, input logic [7:0] owner,
                                                    input logic [10:0] start,
                                                    input logic [LEN_W-1:0] len);
    alloc_result_t res;
    int            i;
    int            k;
    int            run;
    int            run_start;
    int            best_len;
    int            best_start;
    bit            found;
    bit            is_empty;
    res = '{status: ST_DONE, region_start: '0};
    run = 0;
    run_start = 0;
    best_len = 0;
    best_start = 0;
    found = 1'b0;
    if (kind == KIND_ALLOC) begin
      if (len != 0) begin
        // judge each free run only once it has ended
        for (i = 0; i <= CAPACITY; i++) begin
          is_empty = (i < CAPACITY) && (unit_tag[i] == '0);
          if (is_empty) begin
            if (run == 0) run_start = i;
            run++;
          end else begin
            if (run >= int'(len) && (!found || run < best_len)) begin
              found = 1'b1;
              best_len = run;
              best_start = run_start;
              if (run == int'(len)) break;
            end
            run = 0;
          end
        end
        if (found) begin
          for (k = 0; k < int'(len); k++) unit_tag[best_start + k] = TAG_W'(owner) + 1'b1;
          res.region_start = 11'(best_start);
        end else begin
          res.status = ST_NOFIT;
        end
      end
    end else begin
      if (int'(start) + int'(len) > CAPACITY) begin
        res.status = ST_RANGE;
      end else begin
        for (k = 0; k < int'(len); k++) unit_tag[int'(start) + k] = '0;
      end
    end
    return res;
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] owner, input logic [10:0] start,
                           input logic [LEN_W-1:0] len, output alloc_result_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_owner     <= owner;
    in_start_req <= start;
    in_length    <= len;
    do @(posedge clk); while (in_stall);
    res = predict_outcome(kind, owner, start, len);
    pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    alloc_result_t r;
    tx_idle_pct = 9;
    rx_stall_pct = 84;
    send_item(KIND_ALLOC, 8'h00, 11'h7FF, 12'd0, r);     // zero length
    send_item(KIND_ALLOC, 8'hFF, 11'h000, 12'hFFF, r);   // longer than the map
    send_item(KIND_ALLOC, 8'hA5, 11'h2AA, 12'd2049, r);
    send_item(KIND_ALLOC, 8'h00, 11'h000, 12'd2048, r);  // whole map
    send_item(KIND_ALLOC, 8'h5A, 11'h555, 12'd1, r);     // map full
    send_item(KIND_FREE,  8'hFF, 11'h000, 12'd2048, r);
    send_item(KIND_FREE,  8'h00, 11'h7FF, 12'd1, r);     // last unit, already empty
    send_item(KIND_FREE,  8'h00, 11'h7FF, 12'd2, r);     // one past the end
    send_item(KIND_FREE,  8'h00, 11'h7FF, 12'hFFF, r);
    send_item(KIND_FREE,  8'h00, 11'h400, 12'd0, r);     // zero length free
    // carve holes of different sizes
    send_item(KIND_ALLOC, 8'd1, 11'd0, 12'd10, r);
    send_item(KIND_ALLOC, 8'd2, 11'd0, 12'd5, r);
    send_item(KIND_ALLOC, 8'd3, 11'd0, 12'd3, r);
    send_item(KIND_ALLOC, 8'd4, 11'd0, 12'd20, r);
    send_item(KIND_ALLOC, 8'd5, 11'd0, 12'd2, r);
    send_item(KIND_ALLOC, 8'd6, 11'd0, 12'd6, r);
    send_item(KIND_FREE,  8'd0, 11'd0, 12'd10, r);
    send_item(KIND_FREE,  8'd0, 11'd15, 12'd3, r);
    send_item(KIND_FREE,  8'd0, 11'd38, 12'd2, r);
    send_item(KIND_ALLOC, 8'd7, 11'd0, 12'd3, r);        // exact fit beyond the first fit
    send_item(KIND_ALLOC, 8'd8, 11'd0, 12'd1, r);        // smallest hole wins
    send_item(KIND_ALLOC, 8'd9, 11'd0, 12'd4, r);
    send_item(KIND_FREE,  8'd0, 11'd10, 12'd5, r);
    send_item(KIND_FREE,  8'd0, 11'd18, 12'd5, r);       // clear part of another owner
    send_item(KIND_ALLOC, 8'd10, 11'd0, 12'd4, r);       // smallest fitting hole, not the lowest
    send_item(KIND_FREE,  8'd0, 11'd0, 12'd2048, r);
  endtask

  task automatic test_backpressure();
    alloc_result_t r;
    int            n;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_token++;
    // receiver holds off while items keep coming; frees keep the block quick
    for (n = 0; n < 8; n++) begin
      if (n % 4 == 3) begin
        send_item(KIND_ALLOC, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                  12'($urandom_range(1, 16)), r);
      end else begin
        send_item(KIND_FREE, 8'($urandom_range(255)), 11'($urandom_range(2000)),
                  12'($urandom_range(0, 40)), r);
      end
    end
  endtask

  task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
    alloc_result_t r;
    region_t       reg_entry;
    int            n;
    int            sel;
    int            idx;
    int            len;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        // noise: arbitrary ranges, often past the end
        len = ($urandom_range(1) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 4095);
        if ($urandom_range(3) == 0) begin
          send_item(KIND_ALLOC, 8'($urandom_range(255)), 11'($urandom_range(2047)), '0, r);
        end else begin
          send_item(KIND_FREE, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                    12'(len), r);
        end
      end else if (sel < 45 && live_regions.size() != 0) begin
        idx = $urandom_range(live_regions.size() - 1);
        reg_entry = live_regions[idx];
        live_regions.delete(idx);
        last_freed_len = reg_entry.count;
        send_item(KIND_FREE, 8'($urandom_range(255)), 11'(reg_entry.first),
                  12'(reg_entry.count), r);
      end else begin
        sel = $urandom_range(99);
        if (sel < 30) len = last_freed_len;
        else if (sel < 75) len = $urandom_range(1, 32);
        else if (sel < 92) len = $urandom_range(33, 300);
        else if (sel < 98) len = $urandom_range(301, 1500);
        else len = $urandom_range(1501, 4095);
        send_item(KIND_ALLOC, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                  12'(len), r);
        if (r.status == ST_DONE) live_regions.push_back('{int'(r.region_start), len});
      end
    end
  endtask

  // check each result, then pick the stall for the next cycle
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d region_start %0d", out_status, out_region_start);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_res.status, out_status);
          error_count++;
        end
        if (out_region_start !== exp_res.region_start) begin
          $error("region_start mismatch: expected %0d, got %0d", exp_res.region_start,
                 out_region_start);
          error_count++;
        end
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    foreach (unit_tag[i]) unit_tag[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_traffic(85, 9, 84);
    wait_drained();
    test_random_traffic(85, 84, 9);
    wait_drained();
    test_random_traffic(85, 0, 0);
    wait_drained();
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
